// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL. Both macros sample on clk and are
// disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

// ----- sv/bspe_pkg.sv -----
`default_nettype none
package bspe_pkg;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;
	localparam int IDX_W     = 7;
	localparam int DEG_W     = 3;
	localparam int CNT_W     = 7;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int STAT_W    = 2;

	localparam int DEF_MAX_COEFFS = 64;
	localparam int DEF_MAX_DEGREE = 7;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic [DEG_W-1:0] RST_DEGREE = DEG_W'(3);
	localparam logic [CNT_W-1:0] RST_COUNT  = CNT_W'(4);

	localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_EXTRAP = CFG_IDX_W'(2);

	localparam logic [OP_W-1:0] OP_KNOT = OP_W'(0);
	localparam logic [OP_W-1:0] OP_COEF = OP_W'(1);
	localparam logic [OP_W-1:0] OP_EVAL = OP_W'(2);

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_DOMAIN = 2'd1,
		ST_DEGREE = 2'd2,
		ST_SAT    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_KNOT,
		K_COEF,
		K_QUERY
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [IDX_W-1:0]          index;
		logic signed [DATA_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [DEG_W-1:0] degree;
		logic [CNT_W-1:0] coeff_count;
		logic             extrapolate;
	} cfg_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_RD_LO,
		E_RD_HI,
		E_CHECK,
		E_SRCH_RD,
		E_SRCH_CMP,
		E_LD_RD,
		E_LD_WR,
		E_BL_TI,
		E_BL_TG,
		E_BL_DIV,
		E_BL_WAIT,
		E_BL_MUL,
		E_BL_FIN,
		E_OUT
	} eng_state_t;
endpackage
`default_nettype wire

// ----- sv/bspe_front.sv -----
`default_nettype none
module bspe_front #(
	parameter int MAX_COEFFS = bspe_pkg::DEF_MAX_COEFFS,
	parameter int MAX_DEGREE = bspe_pkg::DEF_MAX_DEGREE
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [bspe_pkg::OP_W-1:0]           op,
	input  wire logic [bspe_pkg::IDX_W-1:0]          index,
	input  wire logic signed [bspe_pkg::DATA_W-1:0]  value,
	input  wire logic                                pop,
	output logic                                     avail,
	output bspe_pkg::item_t                          item
);
	import bspe_pkg::*;

	localparam int KDEPTH = MAX_COEFFS + MAX_DEGREE + 1;

	item_t       q_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        accept, keep;
	item_t       cls;
	logic [31:0] idx_ext;

	assign busy    = (cnt_q == 2'd2);
	assign avail   = (cnt_q != 2'd0);
	assign item    = q_q[rd_ptr_q];
	assign accept  = start && !busy;
	assign idx_ext = 32'(index);

	// Ops that change nothing are dropped here and never reach the back end.
	always_comb begin
		cls.index = index;
		cls.value = value;
		cls.kind  = K_QUERY;
		keep      = 1'b0;
		if (op == OP_KNOT) begin
			cls.kind = K_KNOT;
			keep     = (idx_ext < 32'(KDEPTH));
		end else if (op == OP_COEF) begin
			cls.kind = K_COEF;
			keep     = (idx_ext < 32'(MAX_COEFFS));
		end else if (op == OP_EVAL) begin
			keep = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep)
			q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (accept && keep)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'((accept && keep) ? 1 : 0) - 2'(pop ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

// ----- sv/bspe_div.sv -----
`default_nettype none
module bspe_div #(
	parameter int NUMW = 49,
	parameter int DENW = 33
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NUMW-1:0] num,
	input  wire logic [DENW-1:0] den,
	output logic                 done,
	output logic [NUMW-1:0]      quo
);
	localparam int CW = $clog2(NUMW + 1);

	logic [DENW-1:0] rem_q, den_q;
	logic [NUMW-1:0] quo_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q, done_q;
	logic [DENW:0]   sh;
	logic            fit;

	assign sh   = {rem_q, quo_q[NUMW-1]};
	assign fit  = (sh >= {1'b0, den_q});
	assign done = done_q;
	assign quo  = quo_q;

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= fit ? DENW'(sh - {1'b0, den_q}) : DENW'(sh);
			quo_q <= {quo_q[NUMW-2:0], fit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NUMW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/bspe_engine.sv -----
`default_nettype none
module bspe_engine #(
	parameter int MAX_COEFFS = bspe_pkg::DEF_MAX_COEFFS,
	parameter int MAX_DEGREE = bspe_pkg::DEF_MAX_DEGREE,
	parameter int FRAC_BITS  = bspe_pkg::DEF_FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bspe_pkg::cfg_t                 cfg,
	input  wire logic                           avail,
	input  wire bspe_pkg::item_t                item,
	output logic                                pop,
	output logic                                valid,
	output logic signed [bspe_pkg::DATA_W-1:0]  result,
	output logic [bspe_pkg::STAT_W-1:0]         status
);
	import bspe_pkg::*;

	localparam int KDEPTH = MAX_COEFFS + MAX_DEGREE + 1;
	localparam int KIW    = $clog2(KDEPTH);
	localparam int CIW    = $clog2(MAX_COEFFS);
	localparam int DDEPTH = MAX_DEGREE + 1;
	localparam int DIW    = $clog2(DDEPTH);
	localparam int NUMW   = 33 + FRAC_BITS;
	localparam int DENW   = 33;
	localparam int MCH    = 16;
	localparam int NCH    = (NUMW + MCH - 1) / MCH;
	localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int PW     = NCH * MCH + DENW;

	localparam logic [PW-1:0] LIM  = PW'(1) << (32 + FRAC_BITS);
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [34:0] SMAX = 35'sd2147483647;
	localparam logic signed [34:0] SMIN = -35'sd2147483648;

	logic signed [DATA_W-1:0] knot_mem [KDEPTH];
	logic signed [DATA_W-1:0] coef_mem [MAX_COEFFS];
	logic signed [DATA_W-1:0] d_mem    [DDEPTH];
	logic signed [DATA_W-1:0] knot_rd_q, coef_rd_q, da_rd_q, db_rd_q;

	eng_state_t state_q, state_d;

	logic                     knot_we, coef_we, d_we, div_start, div_done;
	logic [KIW-1:0]           knot_wa, knot_ra;
	logic [CIW-1:0]           coef_wa, coef_ra;
	logic [DIW-1:0]           d_wa, da_ra, db_ra;
	logic signed [DATA_W-1:0] d_wd;

	logic signed [DATA_W-1:0] x_q, tlo_q, ti_q, dj_q, djm_q, res_q;
	logic [DEG_W-1:0]         deg_q;
	logic [KIW-1:0]           n_q, lo_q, hi_q, span_q;
	logic [DIW-1:0]           j_q, r_q;
	logic                     aneg_q, dneg_q, sat_q;
	logic [DENW-1:0]          md_q;
	logic [NUMW-1:0]          ma_q, quo;
	logic [PW-1:0]            acc_q;
	logic [CHW-1:0]           ch_q;
	status_t                  stat_q;

	logic [31:0]              cnt_ext, n_full, deg_ext, idx_ext;
	logic                     deg_bad;
	logic [KIW-1:0]           deg_k, mid, i_idx, g_idx, k_idx;
	logic [KIW:0]             lohi;
	logic [DIW-1:0]           deg_d;
	logic signed [32:0]       gap, num, diff;
	logic [32:0]              gap_mag, num_mag;
	logic [NCH*MCH-1:0]       ma_pad;
	logic [MCH+DENW-1:0]      pp;
	logic [33:0]              tv;
	logic signed [34:0]       bsum;
	logic signed [DATA_W-1:0] nv;
	logic                     nv_sat, bl_neg;

	assign cnt_ext = 32'(cfg.coeff_count);
	assign n_full  = (cnt_ext > 32'(MAX_COEFFS)) ? 32'(MAX_COEFFS) : cnt_ext;
	assign deg_ext = 32'(cfg.degree);
	assign deg_bad = (deg_ext > 32'(MAX_DEGREE)) || (n_full <= deg_ext);
	assign idx_ext = 32'(item.index);

	assign deg_k = KIW'(deg_q);
	assign deg_d = DIW'(deg_q);
	assign lohi  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid   = KIW'(lohi >> 1);
	assign i_idx = span_q - deg_k + KIW'(j_q);
	assign g_idx = i_idx + deg_k + KIW'(1) - KIW'(r_q);
	assign k_idx = i_idx;

	assign gap     = {knot_rd_q[DATA_W-1], knot_rd_q} - {ti_q[DATA_W-1], ti_q};
	assign num     = {x_q[DATA_W-1], x_q} - {ti_q[DATA_W-1], ti_q};
	assign diff    = {dj_q[DATA_W-1], dj_q} - {djm_q[DATA_W-1], djm_q};
	assign gap_mag = gap[32] ? 33'(-gap) : 33'(gap);
	assign num_mag = num[32] ? 33'(-num) : 33'(num);

	assign ma_pad = (NCH * MCH)'(ma_q);
	assign pp     = ma_pad[ch_q*MCH +: MCH] * md_q;

	// Final step of one blend: round the product, add and saturate.
	always_comb begin
		bl_neg = aneg_q ^ dneg_q;
		tv     = 34'((acc_q + HALF) >> FRAC_BITS);
		bsum   = bl_neg ? (35'(djm_q) - $signed({1'b0, tv}))
		                : (35'(djm_q) + $signed({1'b0, tv}));
		nv_sat = 1'b0;
		if (ma_q == '0 || md_q == '0) begin
			nv = djm_q;
		end else if (acc_q > LIM) begin
			nv_sat = 1'b1;
			nv     = bl_neg ? DATA_W'(SMIN) : DATA_W'(SMAX);
		end else if (bsum > SMAX) begin
			nv_sat = 1'b1;
			nv     = DATA_W'(SMAX);
		end else if (bsum < SMIN) begin
			nv_sat = 1'b1;
			nv     = DATA_W'(SMIN);
		end else begin
			nv = DATA_W'(bsum);
		end
	end

	always_ff @(posedge clk) begin
		if (knot_we)
			knot_mem[knot_wa] <= item.value;
		knot_rd_q <= knot_mem[knot_ra];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_wa] <= item.value;
		coef_rd_q <= coef_mem[coef_ra];
	end

	always_ff @(posedge clk) begin
		if (d_we)
			d_mem[d_wa] <= d_wd;
		da_rd_q <= d_mem[da_ra];
		db_rd_q <= d_mem[db_ra];
	end

	bspe_div #(
		.NUMW(NUMW),
		.DENW(DENW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   ({num_mag, FRAC_BITS'(0)}),
		.den   (gap_mag),
		.done  (div_done),
		.quo   (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= E_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		knot_we   = 1'b0;
		coef_we   = 1'b0;
		d_we      = 1'b0;
		div_start = 1'b0;
		knot_wa   = idx_ext[KIW-1:0];
		coef_wa   = idx_ext[CIW-1:0];
		knot_ra   = i_idx;
		coef_ra   = k_idx[CIW-1:0];
		d_wa      = j_q;
		d_wd      = nv;
		da_ra     = j_q;
		db_ra     = j_q - DIW'(1);
		valid     = 1'b0;
		case (state_q)
			E_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					case (item.kind)
						K_KNOT:  knot_we = 1'b1;
						K_COEF:  coef_we = 1'b1;
						K_QUERY: state_d = deg_bad ? E_OUT : E_RD_LO;
						default: ;
					endcase
				end
			end
			E_RD_LO: begin
				knot_ra = deg_k;
				state_d = E_RD_HI;
			end
			E_RD_HI: begin
				knot_ra = n_q;
				state_d = E_CHECK;
			end
			E_CHECK: begin
				if (!cfg.extrapolate && (x_q < tlo_q || x_q > knot_rd_q))
					state_d = E_OUT;
				else if (x_q <= tlo_q || x_q >= knot_rd_q)
					state_d = E_LD_RD;
				else
					state_d = E_SRCH_RD;
			end
			E_SRCH_RD: begin
				knot_ra = mid;
				state_d = (hi_q - lo_q > KIW'(1)) ? E_SRCH_CMP : E_LD_RD;
			end
			E_SRCH_CMP: state_d = E_SRCH_RD;
			E_LD_RD:    state_d = E_LD_WR;
			E_LD_WR: begin
				d_we = 1'b1;
				d_wd = (k_idx < n_q) ? coef_rd_q : '0;
				if (j_q == deg_d)
					state_d = (deg_d == '0) ? E_OUT : E_BL_TI;
				else
					state_d = E_LD_RD;
			end
			E_BL_TI: state_d = E_BL_TG;
			E_BL_TG: begin
				knot_ra = g_idx;
				state_d = E_BL_DIV;
			end
			E_BL_DIV: begin
				if (gap == '0) begin
					state_d = E_BL_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = E_BL_WAIT;
				end
			end
			E_BL_WAIT: if (div_done) state_d = E_BL_MUL;
			E_BL_MUL:  if (ch_q == CHW'(NCH - 1)) state_d = E_BL_FIN;
			E_BL_FIN: begin
				d_we = 1'b1;
				if (j_q == r_q && r_q == deg_d)
					state_d = E_OUT;
				else
					state_d = E_BL_TI;
			end
			E_OUT: begin
				valid   = 1'b1;
				state_d = E_IDLE;
			end
			default: state_d = E_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				x_q    <= item.value;
				deg_q  <= cfg.degree;
				n_q    <= KIW'(n_full);
				sat_q  <= 1'b0;
				res_q  <= '0;
				stat_q <= deg_bad ? ST_DEGREE : ST_OK;
				j_q    <= '0;
			end
			E_RD_HI: tlo_q <= knot_rd_q;
			E_CHECK: begin
				if (!cfg.extrapolate && (x_q < tlo_q || x_q > knot_rd_q))
					stat_q <= ST_DOMAIN;
				if (x_q <= tlo_q)
					span_q <= deg_k;
				else if (x_q >= knot_rd_q)
					span_q <= n_q - KIW'(1);
				lo_q <= deg_k;
				hi_q <= n_q;
			end
			E_SRCH_RD: span_q <= lo_q;
			E_SRCH_CMP: begin
				if (knot_rd_q <= x_q)
					lo_q <= mid;
				else
					hi_q <= mid;
			end
			E_LD_WR: begin
				if (j_q == deg_d) begin
					r_q   <= DIW'(1);
					res_q <= (k_idx < n_q) ? coef_rd_q : '0;
				end else begin
					j_q <= j_q + DIW'(1);
				end
			end
			E_BL_TG: begin
				ti_q  <= knot_rd_q;
				dj_q  <= da_rd_q;
				djm_q <= db_rd_q;
			end
			E_BL_DIV: begin
				ma_q   <= '0;
				aneg_q <= num[32] ^ gap[32];
				dneg_q <= diff[32];
				md_q   <= diff[32] ? 33'(-diff) : 33'(diff);
			end
			E_BL_WAIT: begin
				ma_q  <= quo;
				acc_q <= '0;
				ch_q  <= '0;
			end
			E_BL_MUL: begin
				acc_q <= acc_q + (PW'(pp) << (ch_q * MCH));
				ch_q  <= ch_q + CHW'(1);
			end
			E_BL_FIN: begin
				res_q  <= nv;
				if (nv_sat) begin
					sat_q  <= 1'b1;
					stat_q <= ST_SAT;
				end
				if (j_q != r_q) begin
					j_q <= j_q - DIW'(1);
				end else begin
					r_q <= r_q + DIW'(1);
					j_q <= deg_d;
				end
			end
			default: ;
		endcase
	end

	assign result = res_q;
	assign status = (sat_q && stat_q == ST_OK) ? ST_SAT : stat_q;
endmodule
`default_nettype wire

// ----- sv/bspline_point_evaluator.sv -----
`default_nettype none
// Channel   Ports                              Beat taken when
// --------  ---------------------------------  -----------------------
// input     start, busy, op, index, value      start high, busy low
// result    valid, result, status              valid high (one cycle)
// config    cfg_we, cfg_index, cfg_data        cfg_we high
//
// A table write passes through the queue and gives no beat.
// A query runs search and load, then degree*(degree+1)/2 blends; the
// shared bit-serial divider computes their alphas.
// Reset clears configuration, queue and sequencer; tables are not cleared.
// The result side cannot stall; busy rises only when the two-entry queue
// in front of the sequencer is full.
module bspline_point_evaluator #(
	parameter int MAX_COEFFS = bspe_pkg::DEF_MAX_COEFFS,
	parameter int MAX_DEGREE = bspe_pkg::DEF_MAX_DEGREE,
	parameter int FRAC_BITS  = bspe_pkg::DEF_FRAC_BITS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [bspe_pkg::OP_W-1:0]           op,
	input  wire logic [bspe_pkg::IDX_W-1:0]          index,
	input  wire logic signed [bspe_pkg::DATA_W-1:0]  value,
	output logic                                     valid,
	output logic signed [bspe_pkg::DATA_W-1:0]       result,
	output logic [bspe_pkg::STAT_W-1:0]              status,
	input  wire logic                                cfg_we,
	input  wire logic [bspe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bspe_pkg::CFG_W-1:0]          cfg_data
);
	import bspe_pkg::*;
	`include "assert_macros.svh"

	cfg_t  cfg_q;
	item_t item;
	logic  avail, pop;

	// Configuration registers. Writes to the unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.degree      <= RST_DEGREE;
			cfg_q.coeff_count <= RST_COUNT;
			cfg_q.extrapolate <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEGREE: cfg_q.degree      <= cfg_data[DEG_W-1:0];
				REG_COUNT:  cfg_q.coeff_count <= cfg_data[CNT_W-1:0];
				REG_EXTRAP: cfg_q.extrapolate <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front end classifies each beat and queues it; op 3 and
	// out-of-range writes are dropped there.
	bspe_front #(
		.MAX_COEFFS(MAX_COEFFS),
		.MAX_DEGREE(MAX_DEGREE)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.op    (op),
		.index (index),
		.value (value),
		.pop   (pop),
		.avail (avail),
		.item  (item)
	);

	// The back end owns the tables and runs search, load and blend.
	bspe_engine #(
		.MAX_COEFFS(MAX_COEFFS),
		.MAX_DEGREE(MAX_DEGREE),
		.FRAC_BITS (FRAC_BITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.avail (avail),
		.item  (item),
		.pop   (pop),
		.valid (valid),
		.result(result),
		.status(status)
	);

	// Error answers always carry a zero value.
	`AST_IMP(a_err_zero, valid && (status == ST_DOMAIN || status == ST_DEGREE), result == '0)
	// No result follows directly on another; the sequencer returns to fetch between them.
	`AST_NEXT(a_no_double, valid, !valid)
	// The sequencer never pops from an empty queue.
	`AST_IMP(a_pop_avail, pop, avail)
endmodule
`default_nettype wire
